>>> rtl/enhanced_clock_page_replacement_assert.svh
// Assertion macros for the clock replacement block.
// Both use clk_i and rst_ni of the module that includes this file.
`ifndef ENHANCED_CLOCK_PAGE_REPLACEMENT_ASSERT_SVH
`define ENHANCED_CLOCK_PAGE_REPLACEMENT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define ECPR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ecpr assertion failed");
// Next-cycle implication.
`define ECPR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ecpr assertion failed");
`else
`define ECPR_ASSERT_IMP(lbl, ante, cons)
`define ECPR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/ecpr_pkg.sv
package ecpr_pkg;

  localparam int CFG_W       = 4;
  localparam int FRAME_IDX_W = 3;
  localparam int TOTAL_W     = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef struct packed {
    logic                   fault;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   writeback_needed;
    logic [TOTAL_W-1:0]     fault_total;
  } ecpr_result_t;

endpackage

>>> rtl/ecpr_req_if.sv
interface ecpr_req_if #(
  parameter int PAGE_WIDTH = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [PAGE_WIDTH-1:0] page_number;
  logic                  is_write;
  logic                  last_reference;

  modport source (output valid, output page_number, output is_write,
                  output last_reference, input ready);
  modport sink   (input valid, input page_number, input is_write,
                  input last_reference, output ready);
endinterface

>>> rtl/ecpr_res_if.sv
interface ecpr_res_if
  import ecpr_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   fault;
  logic [FRAME_IDX_W-1:0] frame_index;
  logic                   writeback_needed;
  logic [TOTAL_W-1:0]     fault_total;

  modport source (output valid, output fault, output frame_index,
                  output writeback_needed, output fault_total, input ready);
  modport sink   (input valid, input fault, input frame_index,
                  input writeback_needed, input fault_total, output ready);
endinterface

>>> rtl/ecpr_ram.sv
module ecpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ecpr_ctrl.sv
module ecpr_ctrl
  import ecpr_pkg::*;
#(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CFG_W-1:0]      cfg_frames_i,
  input  logic                  start_i,
  input  logic [PAGE_WIDTH-1:0] page_i,
  input  logic                  is_write_i,
  input  logic                  last_i,
  output logic                  idle_o,
  output logic                  res_valid_o,
  output ecpr_result_t          res_o,
  input  logic                  res_take_i
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_SWEEP  = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [PAGE_WIDTH-1:0] page_q;
  logic                  wr_q, last_q;
  logic [CNT_W-1:0]      n_q, n_d;
  logic [IDX_W-1:0]      last_idx;
  logic [IDX_W-1:0]      scan_q, scan_d;
  logic                  scan_done_q, scan_done_d;
  logic [IDX_W-1:0]      cmp_q, cmp_d;
  logic                  cmp_act_q, cmp_act_d;
  logic                  hit_q, hit_d;
  logic [IDX_W-1:0]      where_q, where_d;
  logic [IDX_W-1:0]      hand_q, hand_d, hand_nxt;
  logic [IDX_W-1:0]      step_q, step_d;
  logic                  want_q, want_d;
  logic [TOTAL_W-1:0]    fcnt_q, fcnt_d;
  logic [MAX_FRAMES-1:0] valid_q, valid_d;
  logic [MAX_FRAMES-1:0] ref_q, ref_d;
  logic [MAX_FRAMES-1:0] dirty_q, dirty_d;
  ecpr_result_t          res_q, res_d;

  logic [IDX_W-1:0]      sel;
  logic                  issue;
  logic                  match;
  logic                  take;
  logic                  finish;
  logic                  ram_we;
  logic [PAGE_WIDTH-1:0] rdata;

  // Clamp the frame count to 1..MAX_FRAMES
  always_comb begin
    if (cfg_frames_i == '0) begin
      n_d = CNT_W'(1);
    end else if (CMP_W'(cfg_frames_i) > CMP_W'(MAX_FRAMES)) begin
      n_d = CNT_W'(MAX_FRAMES);
    end else begin
      n_d = CNT_W'(cfg_frames_i);
    end
  end

  assign last_idx = IDX_W'(n_q - CNT_W'(1));
  assign sel      = (state_q == ST_SWEEP) ? hand_q : cmp_q;
  assign hand_nxt = (hand_q == last_idx) ? '0 : hand_q + IDX_W'(1);
  assign issue    = (state_q == ST_LOOKUP) && !scan_done_q;
  assign match    = cmp_act_q && valid_q[sel] && (rdata == page_q);
  assign take     = !ref_q[sel] && (dirty_q[sel] == want_q);
  assign ram_we   = (state_q == ST_SWEEP) && take;

  ecpr_ram #(
    .WIDTH (PAGE_WIDTH),
    .DEPTH (MAX_FRAMES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (hand_q),
    .wdata_i (page_q),
    .raddr_i (scan_q),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    scan_done_d = scan_done_q;
    cmp_d       = cmp_q;
    cmp_act_d   = 1'b0;
    hit_d       = hit_q;
    where_d     = where_q;
    hand_d      = hand_q;
    step_d      = step_q;
    want_d      = want_q;
    fcnt_d      = fcnt_q;
    valid_d     = valid_q;
    ref_d       = ref_q;
    dirty_d     = dirty_q;
    res_d       = res_q;
    finish      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          scan_d      = '0;
          scan_done_d = 1'b0;
          hit_d       = 1'b0;
          state_d     = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // address pipeline: issue one tag read, compare the previous one
        if (issue) begin
          cmp_act_d = 1'b1;
          cmp_d     = scan_q;
          if (scan_q == last_idx) begin
            scan_done_d = 1'b1;
          end else begin
            scan_d = scan_q + IDX_W'(1);
          end
        end
        if (match) begin
          ref_d[sel] = 1'b1;
          if (wr_q) begin
            dirty_d[sel] = 1'b1;
          end
          if (!hit_q) begin
            hit_d   = 1'b1;
            where_d = sel;
          end
        end
        if (cmp_act_q && (cmp_q == last_idx)) begin
          if (hit_q || match) begin
            res_d.fault            = 1'b0;
            res_d.frame_index      = FRAME_IDX_W'(hit_q ? where_q : sel);
            res_d.writeback_needed = 1'b0;
            res_d.fault_total      = fcnt_q;
            finish                 = 1'b1;
          end else begin
            if (fcnt_q != '1) begin
              fcnt_d = fcnt_q + TOTAL_W'(1);
            end
            if (hand_q > last_idx) begin
              hand_d = '0;
            end
            step_d  = '0;
            want_d  = 1'b0;
            state_d = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (take) begin
          res_d.fault            = 1'b1;
          res_d.frame_index      = FRAME_IDX_W'(sel);
          res_d.writeback_needed = valid_q[sel] && dirty_q[sel];
          res_d.fault_total      = fcnt_q;
          valid_d[sel]           = 1'b1;
          ref_d[sel]             = 1'b1;
          dirty_d[sel]           = wr_q;
          finish                 = 1'b1;
        end else begin
          if (want_q) begin
            ref_d[sel] = 1'b0;
          end
          if (step_q == last_idx) begin
            step_d = '0;
            want_d = !want_q;
          end else begin
            step_d = step_q + IDX_W'(1);
          end
        end
        hand_d = hand_nxt;
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish) begin
      state_d = ST_DONE;
      if (last_q) begin
        valid_d = '0;
        ref_d   = '0;
        dirty_d = '0;
        hand_d  = '0;
        fcnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_done_q <= 1'b0;
      cmp_act_q   <= 1'b0;
      hit_q       <= 1'b0;
      hand_q      <= '0;
      want_q      <= 1'b0;
      fcnt_q      <= '0;
      valid_q     <= '0;
      ref_q       <= '0;
      dirty_q     <= '0;
    end else begin
      state_q     <= state_d;
      scan_done_q <= scan_done_d;
      cmp_act_q   <= cmp_act_d;
      hit_q       <= hit_d;
      hand_q      <= hand_d;
      want_q      <= want_d;
      fcnt_q      <= fcnt_d;
      valid_q     <= valid_d;
      ref_q       <= ref_d;
      dirty_q     <= dirty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == ST_IDLE)) begin
      page_q <= page_i;
      wr_q   <= is_write_i;
      last_q <= last_i;
      n_q    <= n_d;
    end
    scan_q  <= scan_d;
    cmp_q   <= cmp_d;
    where_q <= where_d;
    step_q  <= step_d;
    res_q   <= res_d;
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

endmodule

>>> rtl/enhanced_clock_page_replacement.sv
// Enhanced second-chance (clock) page replacement. Each request is one page
// reference; each gives exactly one result: hit or fault, the frame that now
// holds the page, whether a dirty occupied frame was evicted, and the
// saturating fault count. The frame count (register, 0 acts as 1, above
// MAX_FRAMES acts as MAX_FRAMES) may only be written while the block is idle.
// Timing: the request port is ready only while the sequencer is idle. In
// lookup the page tags sit in a RAM with registered read, and one comparator
// walks them one frame per cycle; the result then passes to the output
// register. A fault adds the clock sweep, which examines one frame per cycle.
// The output register decouples the result side, so a new request is taken
// while an earlier result still waits. No clearing pass is needed after reset.
`include "enhanced_clock_page_replacement_assert.svh"

module enhanced_clock_page_replacement
  import ecpr_pkg::*;
#(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  ecpr_req_if.sink         req_i,
  ecpr_res_if.source       res_o
);

  logic [CFG_W-1:0] cfg_q;       // frames in use
  logic             idle;
  logic             start;
  logic             ctrl_res_valid;
  ecpr_result_t     ctrl_res;
  logic             res_take;
  logic             out_valid_q;
  ecpr_result_t     out_q;

  // Frame count register, write only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  assign req_i.ready = idle;
  assign start       = req_i.valid && idle;

  // Sequencer: tag lookup, then clock sweep on a miss, sharing the tag RAM
  ecpr_ctrl #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_WIDTH (PAGE_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_frames_i (cfg_q),
    .start_i      (start),
    .page_i       (req_i.page_number),
    .is_write_i   (req_i.is_write),
    .last_i       (req_i.last_reference),
    .idle_o       (idle),
    .res_valid_o  (ctrl_res_valid),
    .res_o        (ctrl_res),
    .res_take_i   (res_take)
  );

  // Output register: loads when empty or being drained this cycle
  assign res_take = ctrl_res_valid && (!out_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= ctrl_res;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.fault            = out_q.fault;
  assign res_o.frame_index      = out_q.frame_index;
  assign res_o.writeback_needed = out_q.writeback_needed;
  assign res_o.fault_total      = out_q.fault_total;

  // A taken request keeps the sequencer busy for at least the next cycle
  `ECPR_ASSERT_NXT(a_busy_after_req, req_i.valid && req_i.ready, !req_i.ready)
  // A hit never reports a writeback
  `ECPR_ASSERT_IMP(a_hit_no_wb, res_o.valid && !res_o.fault, !res_o.writeback_needed)
  // A fault is always counted
  `ECPR_ASSERT_IMP(a_fault_counted, res_o.valid && res_o.fault, res_o.fault_total != '0)

endmodule
